[rtl/s2l_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package s2l_pkg;

  localparam int TableYears = 150;
  localparam int BaseYear   = 1900;
  localparam int OffW       = 18;

  typedef struct packed {
    logic [11:0] solar_year;
    logic [3:0]  solar_month;
    logic [4:0]  solar_day;
  } in_t;

  typedef struct packed {
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        is_leap_month;
    logic        in_range;
  } out_t;

  // Adder / compare unit control
  typedef struct packed {
    logic               sub;
    logic signed [OffW-1:0] a;
    logic signed [OffW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [OffW-1:0] res;
    logic               neg;
  } alu_rsp_t;

  localparam logic [16:0] YEAR_ROM [TableYears] = '{
    17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
    17'h09ad0,17'h055d2,17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,
    17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,
    17'h06d40,17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,17'h06566,17'h0d4a0,
    17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
    17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
    17'h0a950,17'h0b557,17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5d0,17'h14573,
    17'h052d0,17'h0a9a8,17'h0e950,17'h06aa0,17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,
    17'h0a570,17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,17'h096d0,17'h04dd5,
    17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,17'h0b5a0,17'h195a6,
    17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
    17'h0ab60,17'h09570,17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,
    17'h055c0,17'h0ab60,17'h096d5,17'h092e0,17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,
    17'h07552,17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,17'h0a950,17'h0b4a0,
    17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
    17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
    17'h0ea65,17'h0d530,17'h05aa0,17'h076a3,17'h096d0,17'h04bd7,17'h04ad0,17'h0a4d0,
    17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,
    17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
    9'd304, 9'd334
  };

  function automatic logic [16:0] rom_word(input logic [7:0] idx);
    if (idx < 8'(TableYears)) begin
      rom_word = YEAR_ROM[idx];
    end else begin
      rom_word = '0;
    end
  endfunction

  function automatic logic [8:0] leap_len(input logic [16:0] w);
    if (w[3:0] == 4'd0) begin
      leap_len = 9'd0;
    end else begin
      leap_len = w[16] ? 9'd30 : 9'd29;
    end
  endfunction

  function automatic logic [8:0] month_len(input logic [16:0] w, input logic [3:0] m);
    logic [4:0] bit_idx;
    bit_idx   = 5'd16 - {1'b0, m};
    month_len = w[bit_idx] ? 9'd30 : 9'd29;
  endfunction

  function automatic logic [8:0] year_len(input logic [16:0] w);
    logic [8:0] sum;
    sum = 9'd348;
    for (int i = 4; i < 16; i++) begin
      sum = sum + {8'd0, w[i]};
    end
    year_len = sum + leap_len(w);
  endfunction

endpackage
`default_nettype wire

[rtl/s2l_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared add/subtract unit; sign of the result doubles as the a < b compare.
module s2l_alu (
  input  wire  s2l_pkg::alu_req_t req,
  output s2l_pkg::alu_rsp_t       rsp
);
  logic signed [s2l_pkg::OffW-1:0] res;

  assign res     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.res = res;
  assign rsp.neg = res[s2l_pkg::OffW-1];
endmodule
`default_nettype wire

[rtl/solar_to_lunar_date.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                        | Payload
// ---------+------------------------------+-------------------------------
// input    | in_valid, in_stall, in_data  | s2l_pkg::in_t (year/month/day)
// result   | out_valid, out_stall, out_data | s2l_pkg::out_t (lunar date)
//
// One date at a time. A transaction counts days to Jan 1, applies one fix-up,
// then walks the lunar years and the months, all through the single
// add/subtract unit. Inputs that fail the field check go straight to done.
// Reset (rst_n, synchronous) returns to idle and drops out_valid. in_stall
// stays high until the result is taken.
module solar_to_lunar_date (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  s2l_pkg::in_t in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output s2l_pkg::out_t      out_data
);
  typedef enum logic [2:0] {S_IDLE, S_DAYS, S_FIX, S_YEARS, S_MONTHS, S_DONE} state_t;

  localparam int OffW = s2l_pkg::OffW;

  state_t                 state_r, state_nxt;
  logic [11:0]            year_r, year_nxt;
  logic [3:0]             mon_r, mon_nxt;
  logic [4:0]             day_r, day_nxt;
  logic [7:0]             idx_r, idx_nxt;
  logic [3:0]             mi_r, mi_nxt;
  logic                   lph_r, lph_nxt;
  logic [16:0]            word_r, word_nxt;
  logic signed [OffW-1:0] off_r, off_nxt;
  s2l_pkg::out_t          res_r, res_nxt;

  s2l_pkg::alu_req_t      alu_req;
  s2l_pkg::alu_rsp_t      alu_rsp;

  logic                   in_acc;
  logic [11:0]            walk_year;
  logic                   walk_leap, tgt_leap, bad_in;
  logic [7:0]             tgt_idx;
  logic [16:0]            cur_word;
  logic [8:0]             cur_len;
  logic signed [OffW-1:0] fix_add;

  s2l_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = res_r;

  // Gregorian leap test; 1900 is the only century year in span that is not leap
  assign walk_year = 12'(s2l_pkg::BaseYear) + {4'd0, idx_r};
  assign walk_leap = (walk_year[1:0] == 2'd0) && (walk_year != 12'(s2l_pkg::BaseYear));
  assign tgt_leap  = (year_r[1:0] == 2'd0) && (year_r != 12'(s2l_pkg::BaseYear));
  assign tgt_idx   = 8'(year_r - 12'(s2l_pkg::BaseYear));

  assign bad_in = (in_data.solar_year < 12'(s2l_pkg::BaseYear)) ||
                  (in_data.solar_year > 12'(s2l_pkg::BaseYear + s2l_pkg::TableYears)) ||
                  (in_data.solar_month == 4'd0) || (in_data.solar_month > 4'd12) ||
                  (in_data.solar_day == 5'd0);

  assign cur_word = s2l_pkg::rom_word(idx_r);

  // Day-of-year correction relative to Jan 31
  assign fix_add = OffW'($signed({1'b0, s2l_pkg::DAYS_BEFORE[mon_r - 4'd1]}))
                 + OffW'($signed({1'b0, day_r}))
                 + OffW'($signed({1'b0, (tgt_leap && mon_r > 4'd2)}))
                 - OffW'(31);

  // Operand selection for the shared unit
  always_comb begin
    cur_len = '0;
    alu_req = '0;
    alu_req.a = off_r;
    case (state_r)
      S_DAYS: begin
        alu_req.b = walk_leap ? OffW'(366) : OffW'(365);
      end
      S_FIX: begin
        alu_req.b = fix_add;
      end
      S_YEARS: begin
        cur_len     = s2l_pkg::year_len(cur_word);
        alu_req.sub = 1'b1;
        alu_req.b   = OffW'($signed({1'b0, cur_len}));
      end
      S_MONTHS: begin
        cur_len     = lph_r ? s2l_pkg::leap_len(word_r) : s2l_pkg::month_len(word_r, mi_r);
        alu_req.sub = 1'b1;
        alu_req.b   = OffW'($signed({1'b0, cur_len}));
      end
      default: begin
        alu_req.b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    idx_nxt   = idx_r;
    mi_nxt    = mi_r;
    lph_nxt   = lph_r;
    word_nxt  = word_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          year_nxt = in_data.solar_year;
          mon_nxt  = in_data.solar_month;
          day_nxt  = in_data.solar_day;
          idx_nxt  = '0;
          off_nxt  = '0;
          res_nxt  = '0;
          state_nxt = bad_in ? S_DONE : S_DAYS;
        end
      end
      S_DAYS: begin
        if (idx_r == tgt_idx) begin
          state_nxt = S_FIX;
        end else begin
          off_nxt = alu_rsp.res;
          idx_nxt = idx_r + 8'd1;
        end
      end
      S_FIX: begin
        idx_nxt = '0;
        off_nxt = alu_rsp.res;
        state_nxt = alu_rsp.neg ? S_DONE : S_YEARS;
      end
      S_YEARS: begin
        if (idx_r == 8'(s2l_pkg::TableYears)) begin
          state_nxt = S_DONE;
        end else if (alu_rsp.neg) begin
          word_nxt  = cur_word;
          mi_nxt    = 4'd1;
          lph_nxt   = 1'b0;
          state_nxt = S_MONTHS;
        end else begin
          off_nxt = alu_rsp.res;
          idx_nxt = idx_r + 8'd1;
        end
      end
      S_MONTHS: begin
        if (alu_rsp.neg) begin
          res_nxt.lunar_year    = walk_year;
          res_nxt.lunar_month   = mi_r;
          res_nxt.lunar_day     = day_r;
          res_nxt.lunar_day     = 5'(off_r) + 5'd1;
          res_nxt.is_leap_month = lph_r;
          res_nxt.in_range      = 1'b1;
          state_nxt = S_DONE;
        end else begin
          off_nxt = alu_rsp.res;
          if (!lph_r && word_r[3:0] != 4'd0 && mi_r == word_r[3:0]) begin
            lph_nxt = 1'b1;
          end else if (mi_r == 4'd12) begin
            state_nxt = S_DONE;
          end else begin
            lph_nxt = 1'b0;
            mi_nxt  = mi_r + 4'd1;
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    idx_r  <= idx_nxt;
    mi_r   <= mi_nxt;
    lph_r  <= lph_nxt;
    word_r <= word_nxt;
    off_r  <= off_nxt;
    res_r  <= res_nxt;
  end

  // Checks
  a_inrange_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_range) |->
      (out_data.lunar_day != 5'd0 && out_data.lunar_month != 4'd0))
    else $error("in-range result with zero day or month");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |->
      (out_data.lunar_year == 12'd0 && out_data.lunar_month == 4'd0 &&
       out_data.lunar_day == 5'd0 && !out_data.is_leap_month))
    else $error("out-of-range result not cleared");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !$past(out_valid)))
    else $error("accepted while busy or not busy after accept");

endmodule
`default_nettype wire

[test/solar_to_lunar_date_test.sv]
`timescale 1ns / 1ps
module solar_to_lunar_date_test;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  s2l_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  s2l_pkg::out_t out_data;

  solar_to_lunar_date dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Calendar table, own copy of the packed year words
  localparam logic [16:0] LunarYears [150] = '{
    17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
    17'h09ad0,17'h055d2,17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,
    17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,
    17'h06d40,17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,17'h06566,17'h0d4a0,
    17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
    17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
    17'h0a950,17'h0b557,17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5d0,17'h14573,
    17'h052d0,17'h0a9a8,17'h0e950,17'h06aa0,17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,
    17'h0a570,17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,17'h096d0,17'h04dd5,
    17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,17'h0b5a0,17'h195a6,
    17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
    17'h0ab60,17'h09570,17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,
    17'h055c0,17'h0ab60,17'h096d5,17'h092e0,17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,
    17'h07552,17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,17'h0a950,17'h0b4a0,
    17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
    17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
    17'h0ea65,17'h0d530,17'h05aa0,17'h076a3,17'h096d0,17'h04bd7,17'h04ad0,17'h0a4d0,
    17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,
    17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0
  };
  localparam int MonthStart [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  function automatic int days_to_year(input int y);
    return 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
  endfunction

  function automatic int intercalary_days(input logic [16:0] w);
    if (w[3:0] == 4'd0) return 0;
    return w[16] ? 30 : 29;
  endfunction

  function automatic int lunar_year_days(input logic [16:0] w);
    int n;
    n = 348;
    for (int b = 4; b < 16; b++) n += w[b];
    return n + intercalary_days(w);
  endfunction

  // Predicted lunar date for one Gregorian date
  function automatic s2l_pkg::out_t lunar_date_of(input s2l_pkg::in_t d);
    s2l_pkg::out_t r;
    int y, m, dd, off, yi, len;
    logic [16:0] w;
    r = '0;
    y = d.solar_year; m = d.solar_month; dd = d.solar_day;
    if (y < 1900 || m < 1 || m > 12 || dd < 1) return r;
    off = days_to_year(y) - days_to_year(1900) + MonthStart[m-1] + dd - 31;
    if ((((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) && m > 2) off++;
    if (off < 0) return r;
    for (yi = 0; yi < 150; yi++) begin
      len = lunar_year_days(LunarYears[yi]);
      if (off < len) break;
      off -= len;
    end
    if (yi >= 150) return r;
    w = LunarYears[yi];
    for (int mi = 1; mi <= 12; mi++) begin
      len = w[16-mi] ? 30 : 29;
      if (off < len) begin
        r.lunar_year = 12'(1900 + yi); r.lunar_month = 4'(mi);
        r.lunar_day = 5'(off + 1); r.in_range = 1'b1;
        return r;
      end
      off -= len;
      if (w[3:0] != 0 && mi == w[3:0]) begin
        len = intercalary_days(w);
        if (off < len) begin
          r.lunar_year = 12'(1900 + yi); r.lunar_month = 4'(mi);
          r.lunar_day = 5'(off + 1); r.is_leap_month = 1'b1; r.in_range = 1'b1;
          return r;
        end
        off -= len;
      end
    end
    return r;
  endfunction

  s2l_pkg::in_t  pending_dates[$];
  s2l_pkg::out_t expected_dates[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  bit   loaded = 1'b0;
  logic in_stall_s = 1'b1;

  task automatic report(input string what, input s2l_pkg::out_t got,
                        input s2l_pkg::out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: moves pending dates onto the input channel
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_s) begin
        if (send_gap == 0 && pending_dates.size() > 0) begin
          in_data <= pending_dates.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_dates.size() > 0) begin
          in_data <= pending_dates.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // Stall sampled at the rising edge so the driver sees the accept decision
  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (in_valid && !in_stall) begin
      expected_dates.push_back(lunar_date_of(in_data));
      if (!calm && send_gap == 0 && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 6);
    end
  end

  // Receiver back-pressure: random bursts plus one long hold
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 2000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 6);
    end
  end

  // Monitor: compares each result transaction with the oldest prediction
  always @(posedge clk) begin
    s2l_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        report("unexpected", out_data, '0);
      end else begin
        want = expected_dates.pop_front();
        if (out_data.lunar_year !== want.lunar_year) report("year", out_data, want);
        if (out_data.lunar_month !== want.lunar_month) report("month", out_data, want);
        if (out_data.lunar_day !== want.lunar_day) report("day", out_data, want);
        if (out_data.is_leap_month !== want.is_leap_month) report("leap", out_data, want);
        if (out_data.in_range !== want.in_range) report("range", out_data, want);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel outside the long hold
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_left > 0)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic s2l_pkg::in_t mk(input int y, input int m, input int d);
    s2l_pkg::in_t t;
    t.solar_year = 12'(y); t.solar_month = 4'(m); t.solar_day = 5'(d);
    return t;
  endfunction

  initial begin
    int k, lim;
    // Directed: span edges, bad fields, lunar new years, leap months
    pending_dates.push_back(mk(1900, 1, 30));
    pending_dates.push_back(mk(1900, 1, 31));
    pending_dates.push_back(mk(1900, 2, 1));
    pending_dates.push_back(mk(2050, 1, 22));
    pending_dates.push_back(mk(2050, 1, 23));
    pending_dates.push_back(mk(2050, 12, 31));
    pending_dates.push_back(mk(2049, 12, 31));
    pending_dates.push_back(mk(2000, 0, 5));
    pending_dates.push_back(mk(2000, 13, 5));
    pending_dates.push_back(mk(2000, 15, 5));
    pending_dates.push_back(mk(2000, 3, 0));
    pending_dates.push_back(mk(2001, 2, 31));
    pending_dates.push_back(mk(1899, 12, 31));
    pending_dates.push_back(mk(4095, 12, 31));
    pending_dates.push_back(mk(0, 0, 0));
    pending_dates.push_back(mk(2023, 1, 22));
    pending_dates.push_back(mk(2023, 3, 22));
    pending_dates.push_back(mk(2023, 4, 19));
    pending_dates.push_back(mk(2023, 4, 20));
    pending_dates.push_back(mk(2020, 5, 23));
    pending_dates.push_back(mk(2020, 6, 21));
    pending_dates.push_back(mk(2000, 2, 29));
    pending_dates.push_back(mk(1900, 12, 31));
    pending_dates.push_back(mk(2047, 31 % 16, 31));
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Random dates: mostly in span, some noisy fields, a few over the full width
    for (k = 0; k < 400; k++) begin
      case ($urandom_range(0, 9))
        0: pending_dates.push_back(s2l_pkg::in_t'($urandom));
        1: pending_dates.push_back(mk($urandom_range(1880, 2070), $urandom_range(0, 15),
                                      $urandom_range(0, 31)));
        default: pending_dates.push_back(mk($urandom_range(1900, 2050), $urandom_range(1, 12),
                                            $urandom_range(1, 31)));
      endcase
      if (k == 150) hold_req = 1'b1;
    end
    // Last stretch without idling on either side
    wait (pending_dates.size() < 40);
    calm = 1'b1;
    wait (pending_dates.size() == 0 && !in_valid);
    lim = 0;
    while (expected_dates.size() != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/s2l_pkg.sv
rtl/s2l_alu.sv
rtl/solar_to_lunar_date.sv
test/solar_to_lunar_date_test.sv
